### design/tic_pkg.sv
// Shared types and constants for the timer and interrupt controller.
// Used by every module of the block; depends on nothing else.
package tic_pkg;

    // Request and enable bit positions
    localparam logic [4:0] REQ_VBLANK = 5'b00001;
    localparam logic [4:0] REQ_TIMER  = 5'b00100;
    localparam logic [4:0] REQ_JOYPAD = 5'b10000;

    // Dispatch vectors
    localparam logic [7:0] VEC_NONE   = 8'h00;
    localparam logic [7:0] VEC_VBLANK = 8'h40;
    localparam logic [7:0] VEC_TIMER  = 8'h50;
    localparam logic [7:0] VEC_JOYPAD = 8'h60;

    // Clock select codes
    localparam logic [1:0] CLK_SEL_1024 = 2'd0;
    localparam logic [1:0] CLK_SEL_16   = 2'd1;
    localparam logic [1:0] CLK_SEL_64   = 2'd2;
    localparam logic [1:0] CLK_SEL_256  = 2'd3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIMER_ENABLE    = 2'd0,
        CFG_CLOCK_SELECT    = 2'd1,
        CFG_TIMER_MODULO    = 2'd2,
        CFG_IRQ_ENABLE_MASK = 2'd3
    } t_cfg_index;

    // One input item
    typedef struct packed {
        logic [7:0]  elapsed_cycles;
        logic        vblank_request;
        logic        joypad_request;
        logic        master_enable;
        logic        cpu_halted;
        logic [15:0] program_counter;
    } t_item;

    // Interrupt side of one result item
    typedef struct packed {
        logic [4:0]  request_flags;
        logic        take_interrupt;
        logic [7:0]  vector_address;
        logic [15:0] return_address;
        logic        wake_from_halt;
        logic        dispatch_blocked;
    } t_irq_result;

    // Prescaler shift (log2 of cycles per count) for a clock select code
    function automatic logic [3:0] rate_shift(input logic [1:0] sel);
        logic [3:0] sh;
        unique case (sel)
            CLK_SEL_1024: sh = 4'd10;
            CLK_SEL_16:   sh = 4'd4;
            CLK_SEL_64:   sh = 4'd6;
            CLK_SEL_256:  sh = 4'd8;
            default:      sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

### design/tic_timer.sv
// Divider, prescaler and 8-bit timer with modulo reload.
// Depends on tic_pkg for the clock select decode.
module tic_timer
    import tic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_cycles,
    input  logic       i_timer_enable,
    input  logic [1:0] i_clock_select,
    input  logic [7:0] i_timer_modulo,
    output logic [7:0] o_timer_next,
    output logic [7:0] o_divider_next,
    output logic       o_timer_wrap
);

    logic [10:0] r_prescale;
    logic [7:0]  r_timer;
    logic [7:0]  r_divider;

    logic [10:0] n_prescale;
    logic [7:0]  n_timer;
    logic [7:0]  n_divider;

    logic [3:0]  w_shift;
    logic [10:0] w_sum;
    logic [10:0] w_quot;
    logic [6:0]  w_counts;
    logic [8:0]  w_timer_sum;

    // Split prescaler plus cycles into whole counts and remainder
    always_comb begin
        w_shift     = rate_shift(i_clock_select);
        w_sum       = r_prescale + {3'b000, i_cycles};
        w_quot      = w_sum >> w_shift;
        w_counts    = w_quot[6:0];
        w_timer_sum = {1'b0, r_timer} + {2'b00, w_counts};
    end

    // Next timer state; reload from modulo on wrap
    always_comb begin
        n_divider    = r_divider + 8'd1;
        n_prescale   = r_prescale;
        n_timer      = r_timer;
        o_timer_wrap = 1'b0;
        if (i_timer_enable) begin
            n_prescale = w_sum & ~({11{1'b1}} << w_shift);
            if (w_timer_sum[8]) begin
                n_timer      = i_timer_modulo;
                o_timer_wrap = 1'b1;
            end else begin
                n_timer = w_timer_sum[7:0];
            end
        end
    end

    assign o_timer_next   = n_timer;
    assign o_divider_next = n_divider;

    // Commit state when an item completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_timer    <= '0;
            r_divider  <= '0;
        end else if (i_step) begin
            r_prescale <= n_prescale;
            r_timer    <= n_timer;
            r_divider  <= n_divider;
        end
    end

endmodule

### design/tic_irq.sv
// Request flags and fixed-priority interrupt selection.
// Depends on tic_pkg for request bits, vectors and the result struct.
module tic_irq
    import tic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  logic        i_timer_wrap,
    input  logic [4:0]  i_enable_mask,
    output t_irq_result o_result
);

    logic [4:0] r_pending;
    logic [4:0] n_pending;
    logic [4:0] w_raised;
    logic [4:0] w_ready;
    logic [4:0] w_chosen;
    logic [7:0] w_vector;

    // Latch new requests, then pick the highest priority enabled one
    always_comb begin
        w_raised = r_pending
                 | (i_timer_wrap          ? REQ_TIMER  : 5'b00000)
                 | (i_item.vblank_request ? REQ_VBLANK : 5'b00000)
                 | (i_item.joypad_request ? REQ_JOYPAD : 5'b00000);
        w_ready  = w_raised & i_enable_mask;
        priority if ((w_ready & REQ_VBLANK) != 5'b00000) begin
            w_chosen = REQ_VBLANK;
            w_vector = VEC_VBLANK;
        end else if ((w_ready & REQ_TIMER) != 5'b00000) begin
            w_chosen = REQ_TIMER;
            w_vector = VEC_TIMER;
        end else if ((w_ready & REQ_JOYPAD) != 5'b00000) begin
            w_chosen = REQ_JOYPAD;
            w_vector = VEC_JOYPAD;
        end else begin
            w_chosen = 5'b00000;
            w_vector = VEC_NONE;
        end
    end

    // Dispatch or block; clear the serviced flag on dispatch
    always_comb begin
        o_result  = '0;
        n_pending = w_raised;
        if (w_chosen != 5'b00000) begin
            o_result.wake_from_halt = i_item.cpu_halted;
            if (i_item.master_enable) begin
                o_result.take_interrupt = 1'b1;
                o_result.vector_address = w_vector;
                o_result.return_address = i_item.program_counter;
                n_pending               = w_raised & ~w_chosen;
            end else begin
                o_result.dispatch_blocked = 1'b1;
            end
        end
        o_result.request_flags = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (i_step) begin
            r_pending <= n_pending;
        end
    end

endmodule

### design/timer_and_interrupt_controller.sv
// Top level of the timer and interrupt controller: channels, config registers,
// input and result registers. Depends on tic_pkg, tic_timer and tic_irq.
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+------------------------------
//   input     | in        | i_valid / o_stall   | elapsed cycles, requests, PC
//   result    | out       | o_valid / i_stall   | timer, divider, flags, irq
//   config    | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// One item per clock cycle sustained while the result is not stalled. An
// accepted item sits in the input register, and the combinational timer and
// priority logic loads its result into the result register when the item
// advances. Synchronous active-low reset clears the timer and request state,
// config and valids. A stalled result holds its register; the input
// register still takes an item while the result register is full, and o_stall
// rises only when both registers are full and the result is stalled.
module timer_and_interrupt_controller
    import tic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_elapsed_cycles,
    input  logic        i_vblank_request,
    input  logic        i_joypad_request,
    input  logic        i_master_enable,
    input  logic        i_cpu_halted,
    input  logic [15:0] i_program_counter,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_timer_value,
    output logic [7:0]  o_divider_value,
    output logic [4:0]  o_request_flags,
    output logic        o_take_interrupt,
    output logic [7:0]  o_vector_address,
    output logic [15:0] o_return_address,
    output logic        o_wake_from_halt,
    output logic        o_halt_exit,
    output logic        o_dispatch_blocked,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic        r_timer_enable;
    logic [1:0]  r_clock_select;
    logic [7:0]  r_timer_modulo;
    logic [4:0]  r_irq_enable_mask;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    logic [7:0]  r_timer_value;
    logic [7:0]  r_divider_value;
    t_irq_result r_irq;

    logic        w_accept;
    logic        w_advance;
    logic [7:0]  w_timer_next;
    logic [7:0]  w_divider_next;
    logic        w_timer_wrap;
    t_irq_result w_irq;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_enable    <= 1'b0;
            r_clock_select    <= CLK_SEL_1024;
            r_timer_modulo    <= '0;
            r_irq_enable_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TIMER_ENABLE:    r_timer_enable    <= i_cfg_data[0];
                CFG_CLOCK_SELECT:    r_clock_select    <= i_cfg_data[1:0];
                CFG_TIMER_MODULO:    r_timer_modulo    <= i_cfg_data;
                CFG_IRQ_ENABLE_MASK: r_irq_enable_mask <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Flow control: advance when the result register is free or being taken
    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.elapsed_cycles  <= i_elapsed_cycles;
            r_in.vblank_request  <= i_vblank_request;
            r_in.joypad_request  <= i_joypad_request;
            r_in.master_enable   <= i_master_enable;
            r_in.cpu_halted      <= i_cpu_halted;
            r_in.program_counter <= i_program_counter;
        end
    end

    tic_timer u_timer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_advance),
        .i_cycles       (r_in.elapsed_cycles),
        .i_timer_enable (r_timer_enable),
        .i_clock_select (r_clock_select),
        .i_timer_modulo (r_timer_modulo),
        .o_timer_next   (w_timer_next),
        .o_divider_next (w_divider_next),
        .o_timer_wrap   (w_timer_wrap)
    );

    tic_irq u_irq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_item        (r_in),
        .i_timer_wrap  (w_timer_wrap),
        .i_enable_mask (r_irq_enable_mask),
        .o_result      (w_irq)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_timer_value   <= w_timer_next;
            r_divider_value <= w_divider_next;
            r_irq           <= w_irq;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_timer_value      = r_timer_value;
    assign o_divider_value    = r_divider_value;
    assign o_request_flags    = r_irq.request_flags;
    assign o_take_interrupt   = r_irq.take_interrupt;
    assign o_vector_address   = r_irq.vector_address;
    assign o_return_address   = r_irq.return_address;
    assign o_wake_from_halt   = r_irq.wake_from_halt;
    assign o_halt_exit        = r_irq.wake_from_halt;
    assign o_dispatch_blocked = r_irq.dispatch_blocked;

endmodule

### design/tic_checker.sv
// Port-level checks for the timer and interrupt controller, bound to the top.
// Depends on tic_pkg for vectors and request bits.
module tic_checker
    import tic_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_divider_value,
    input logic [4:0]  o_request_flags,
    input logic        o_take_interrupt,
    input logic [7:0]  o_vector_address,
    input logic [15:0] o_return_address,
    input logic        o_wake_from_halt,
    input logic        o_halt_exit,
    input logic        o_dispatch_blocked
);

    // A dispatch carries a real vector and is never also blocked
    a_take_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_take_interrupt) |->
            ((o_vector_address == VEC_VBLANK || o_vector_address == VEC_TIMER ||
              o_vector_address == VEC_JOYPAD) && !o_dispatch_blocked))
        else $error("dispatch without valid vector or while blocked");

    // No dispatch leaves vector and return address at zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_take_interrupt) |->
            (o_vector_address == VEC_NONE && o_return_address == 16'h0000))
        else $error("vector or return address set without dispatch");

    // The serviced request flag is cleared in the same result
    a_flag_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_take_interrupt) |->
            ((o_vector_address != VEC_VBLANK || (o_request_flags & REQ_VBLANK) == 5'b0) &&
             (o_vector_address != VEC_TIMER  || (o_request_flags & REQ_TIMER)  == 5'b0) &&
             (o_vector_address != VEC_JOYPAD || (o_request_flags & REQ_JOYPAD) == 5'b0)))
        else $error("serviced request flag still pending");

    // Halt wake and halt exit always agree
    a_halt_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_wake_from_halt == o_halt_exit))
        else $error("halt wake and halt exit differ");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_divider_value) &&
                                  $stable(o_request_flags)))
        else $error("stalled result changed");

endmodule

bind timer_and_interrupt_controller tic_checker u_tic_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_divider_value    (o_divider_value),
    .o_request_flags    (o_request_flags),
    .o_take_interrupt   (o_take_interrupt),
    .o_vector_address   (o_vector_address),
    .o_return_address   (o_return_address),
    .o_wake_from_halt   (o_wake_from_halt),
    .o_halt_exit        (o_halt_exit),
    .o_dispatch_blocked (o_dispatch_blocked)
);

### tb/sv/tb_top.sv
// Self-checking bench for timer_and_interrupt_controller: two directed bursts, then random
// CPU steps under changing timer and interrupt settings, checked against an in-bench model.
// Depends on tic_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import tic_pkg::*;

    // One predicted result item
    typedef struct packed {
        logic [7:0]  timer_value;
        logic [7:0]  divider_value;
        logic [4:0]  request_flags;
        logic        take_interrupt;
        logic [7:0]  vector_address;
        logic [15:0] return_address;
        logic        wake_from_halt;
        logic        halt_exit;
        logic        dispatch_blocked;
    } t_step_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_elapsed_cycles = '0;
    logic        i_vblank_request = 1'b0;
    logic        i_joypad_request = 1'b0;
    logic        i_master_enable = 1'b0;
    logic        i_cpu_halted = 1'b0;
    logic [15:0] i_program_counter = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_timer_value;
    logic [7:0]  o_divider_value;
    logic [4:0]  o_request_flags;
    logic        o_take_interrupt;
    logic [7:0]  o_vector_address;
    logic [15:0] o_return_address;
    logic        o_wake_from_halt;
    logic        o_halt_exit;
    logic        o_dispatch_blocked;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    // Stimulus and expectation stores
    t_item     cpu_steps_q[$];
    t_step_out step_results_q[$];
    logic      item_taken = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatches = 0;

    // Model copy of the settings and the block state
    logic       cfg_timer_en = 1'b0;
    logic [1:0] cfg_clk_sel = CLK_SEL_1024;
    logic [7:0] cfg_modulo = '0;
    logic [4:0] cfg_irq_mask = '0;
    int         prescale_cnt = 0;
    int         timer_cnt = 0;
    logic [7:0] divider_cnt = '0;
    logic [4:0] pending_irq = '0;

    timer_and_interrupt_controller DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_elapsed_cycles   (i_elapsed_cycles),
        .i_vblank_request   (i_vblank_request),
        .i_joypad_request   (i_joypad_request),
        .i_master_enable    (i_master_enable),
        .i_cpu_halted       (i_cpu_halted),
        .i_program_counter  (i_program_counter),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_timer_value      (o_timer_value),
        .o_divider_value    (o_divider_value),
        .o_request_flags    (o_request_flags),
        .o_take_interrupt   (o_take_interrupt),
        .o_vector_address   (o_vector_address),
        .o_return_address   (o_return_address),
        .o_wake_from_halt   (o_wake_from_halt),
        .o_halt_exit        (o_halt_exit),
        .o_dispatch_blocked (o_dispatch_blocked),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Advance the timer and divider, latch requests, pick the highest-priority
    // enabled request and dispatch it when the master enable allows
    function automatic t_step_out predict_step(input t_item it);
        t_step_out  r;
        int         rate;
        int         sum;
        int         counts;
        logic [4:0] ready;
        logic [4:0] chosen;
        logic [7:0] vec;
        r = '0;
        divider_cnt = divider_cnt + 8'd1;
        if (cfg_timer_en) begin
            case (cfg_clk_sel)
                CLK_SEL_16:  rate = 16;
                CLK_SEL_64:  rate = 64;
                CLK_SEL_256: rate = 256;
                default:     rate = 1024;
            endcase
            sum = prescale_cnt + int'(it.elapsed_cycles);
            counts = sum / rate;
            prescale_cnt = sum % rate;
            // on wrap, drop leftover counts and reload from the modulo
            if (counts != 0) begin
                if (timer_cnt + counts > 255) begin
                    timer_cnt = int'(cfg_modulo);
                    pending_irq = pending_irq | REQ_TIMER;
                end else begin
                    timer_cnt = timer_cnt + counts;
                end
            end
        end
        if (it.vblank_request) pending_irq = pending_irq | REQ_VBLANK;
        if (it.joypad_request) pending_irq = pending_irq | REQ_JOYPAD;

        ready = pending_irq & cfg_irq_mask;
        chosen = '0;
        vec = VEC_NONE;
        if ((ready & REQ_VBLANK) != 0) begin
            chosen = REQ_VBLANK;
            vec = VEC_VBLANK;
        end else if ((ready & REQ_TIMER) != 0) begin
            chosen = REQ_TIMER;
            vec = VEC_TIMER;
        end else if ((ready & REQ_JOYPAD) != 0) begin
            chosen = REQ_JOYPAD;
            vec = VEC_JOYPAD;
        end

        if (chosen != 0) begin
            r.wake_from_halt = it.cpu_halted;
            r.halt_exit = it.cpu_halted;
            if (!it.master_enable) begin
                r.dispatch_blocked = 1'b1;
            end else begin
                r.take_interrupt = 1'b1;
                r.vector_address = vec;
                r.return_address = it.program_counter;
                pending_irq = pending_irq & ~chosen;
            end
        end
        r.timer_value = 8'(timer_cnt);
        r.divider_value = divider_cnt;
        r.request_flags = pending_irq;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Monitor: check accepted results, then record the prediction for an accepted item
    always @(posedge i_clk) begin
        t_step_out want;
        item_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (step_results_q.size() == 0) begin
                    $display("%0t: result with none expected: timer %0h divider %0h",
                             $time, o_timer_value, o_divider_value);
                    mismatches++;
                end else begin
                    want = step_results_q.pop_front();
                    check_field("timer_value", 16'(want.timer_value), 16'(o_timer_value));
                    check_field("divider_value", 16'(want.divider_value),
                                16'(o_divider_value));
                    check_field("request_flags", 16'(want.request_flags),
                                16'(o_request_flags));
                    check_field("take_interrupt", 16'(want.take_interrupt),
                                16'(o_take_interrupt));
                    check_field("vector_address", 16'(want.vector_address),
                                16'(o_vector_address));
                    check_field("return_address", want.return_address, o_return_address);
                    check_field("wake_from_halt", 16'(want.wake_from_halt),
                                16'(o_wake_from_halt));
                    check_field("halt_exit", 16'(want.halt_exit), 16'(o_halt_exit));
                    check_field("dispatch_blocked", 16'(want.dispatch_blocked),
                                16'(o_dispatch_blocked));
                end
            end
            if (i_valid && !o_stall) begin
                step_results_q.push_back(predict_step({i_elapsed_cycles, i_vblank_request,
                    i_joypad_request, i_master_enable, i_cpu_halted, i_program_counter}));
            end
        end
    end

    // Driver: present the next item once the current one is taken; hold it while stalled
    always @(negedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || item_taken) begin
            if (cpu_steps_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = cpu_steps_q.pop_front();
                i_valid <= 1'b1;
                i_elapsed_cycles <= nxt.elapsed_cycles;
                i_vblank_request <= nxt.vblank_request;
                i_joypad_request <= nxt.joypad_request;
                i_master_enable <= nxt.master_enable;
                i_cpu_halted <= nxt.cpu_halted;
                i_program_counter <= nxt.program_counter;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic push_step(input logic [7:0] cycles, input logic vb, input logic jp,
                             input logic ime, input logic halted, input logic [15:0] pc);
        cpu_steps_q.push_back({cycles, vb, jp, ime, halted, pc});
    endtask

    // Wait for every item to be taken and every result to arrive, then let the pipe drain
    task automatic wait_idle();
        while (cpu_steps_q.size() != 0 || i_valid || step_results_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_TIMER_ENABLE:    cfg_timer_en = value[0];
            CFG_CLOCK_SELECT:    cfg_clk_sel = value[1:0];
            CFG_TIMER_MODULO:    cfg_modulo = value;
            CFG_IRQ_ENABLE_MASK: cfg_irq_mask = value[4:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic en, input logic [1:0] sel,
                                  input logic [7:0] modulo, input logic [4:0] mask);
        write_reg(CFG_TIMER_ENABLE, {7'd0, en});
        write_reg(CFG_CLOCK_SELECT, {6'd0, sel});
        write_reg(CFG_TIMER_MODULO, modulo);
        write_reg(CFG_IRQ_ENABLE_MASK, {3'd0, mask});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender and receiver idle rates: 0 = sender light, 1 = receiver light, 2 = none
    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 32; recv_idle_pct = 68; end
            1: begin send_idle_pct = 68; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    initial begin
        logic [7:0] modulo;
        logic [4:0] mask;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        // Directed: fast rate, wraps with leftover counts, blocked then dispatched requests
        apply_settings(1'b1, CLK_SEL_16, 8'hF0, 5'h1F);
        push_step(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        push_step(8'd255, 1'b1, 1'b1, 1'b0, 1'b1, 16'hFFFF);
        for (int k = 0; k < 15; k++)
            push_step(8'd255, 1'b0, 1'b0, 1'b0, k[0], 16'(k * 16'h1111));
        push_step(8'd1, 1'b0, 1'b0, 1'b1, 1'b1, 16'hFFFF);
        push_step(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8001);
        push_step(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h1234);
        push_step(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000);
        wait_idle();

        // Directed: timer stopped, only the unused enable bits set
        apply_settings(1'b0, CLK_SEL_1024, 8'h00, 5'h0A);
        push_step(8'd200, 1'b1, 1'b1, 1'b1, 1'b1, 16'h5555);
        push_step(8'd255, 1'b0, 1'b1, 1'b0, 1'b1, 16'hAAAA);
        push_step(8'd17, 1'b1, 1'b0, 1'b1, 1'b0, 16'h00FF);
        wait_idle();

        // Random phases, each under its own settings
        for (int p = 0; p < 12; p++) begin
            modulo = (p == 0) ? 8'h00 : (p == 1 || p == 4) ? 8'hFF : 8'($urandom_range(0, 255));
            mask = (p == 2) ? 5'h00 : (p % 3 == 0) ? 5'h1F : 5'($urandom_range(0, 31));
            apply_settings((p != 5), 2'(p % 4), modulo, mask);
            set_idling(p / 4);
            for (int n = 0; n < 140; n++) begin
                push_step(($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0),
                          1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0),
                          16'($urandom));
            end
            wait_idle();
        end

        if (mismatches == 0 && step_results_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
